// ===== hdl/rv32_subset_decode_execute_core_defines.svh =====
// ----------------------------------------------------------------------------
// rv32_subset_decode_execute_core_defines
// Assertion macros shared by the RV32 subset decode/execute core.
// ----------------------------------------------------------------------------
`ifndef RV32_SUBSET_DECODE_EXECUTE_CORE_DEFINES_SVH
`define RV32_SUBSET_DECODE_EXECUTE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RV32SDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32sde assertion failed");

// next-cycle implication
`define RV32SDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32sde assertion failed");

`else

`define RV32SDE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RV32SDE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/rv32sde_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32sde_pkg
// Types, encodings and constants of the RV32 subset decode/execute core.
// ----------------------------------------------------------------------------
package rv32sde_pkg;

  localparam int XLEN    = 32;
  localparam int NREGS   = 32;
  localparam int RIDX_W  = 5;

  localparam logic [XLEN-1:0]   PC_RESET    = 32'h8000_0000;
  localparam logic [XLEN-1:0]   EBREAK_WORD = 32'h0010_0073;
  localparam logic [RIDX_W-1:0] REG_ZERO    = 5'd0;
  localparam logic [RIDX_W-1:0] REG_A0      = 5'd10;

  // item codes
  localparam logic OP_INSTR = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_RETIRED = 3'd0;
  localparam logic [2:0] KIND_STORE   = 3'd1;
  localparam logic [2:0] KIND_LOAD    = 3'd2;
  localparam logic [2:0] KIND_HALT    = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  // access sizes
  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  // major opcodes
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;

  // funct3
  localparam logic [2:0] F3_ADDI = 3'b000;
  localparam logic [2:0] F3_SB   = 3'b000;
  localparam logic [2:0] F3_SW   = 3'b010;
  localparam logic [2:0] F3_LBU  = 3'b100;

  typedef struct packed {
    logic [2:0]      kind;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] store_data;
    logic [2:0]      access_size;
    logic [XLEN-1:0] next_pc;
    logic [XLEN-1:0] halt_code;
  } result_t;

  typedef struct packed {
    logic              emit;
    result_t           res;
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [XLEN-1:0]   rf_wdata;
    logic [XLEN-1:0]   pc_nxt;
    logic              halt_set;
    logic              pend_set;
    logic              pend_clr;
  } exec_t;

endpackage

// ===== hdl/rv32sde_ram.sv =====
// ----------------------------------------------------------------------------
// rv32sde_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rv32sde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== hdl/rv32sde_exec.sv =====
// ----------------------------------------------------------------------------
// rv32sde_exec
// Decode and execute of one item: result fields and state updates.
// ----------------------------------------------------------------------------
module rv32sde_exec (
  input  logic                                    op,
  input  logic [rv32sde_pkg::XLEN-1:0]            word,
  input  logic [7:0]                              load_byte,
  input  logic [rv32sde_pkg::XLEN-1:0]            rs1,
  input  logic [rv32sde_pkg::XLEN-1:0]            rs2,
  input  logic [rv32sde_pkg::XLEN-1:0]            a0,
  input  logic [rv32sde_pkg::XLEN-1:0]            pc,
  input  logic                                    halted,
  input  logic                                    load_pending,
  input  logic [rv32sde_pkg::RIDX_W-1:0]          load_dest,
  output rv32sde_pkg::exec_t                      ex
);

  logic [6:0]                           opc;
  logic [2:0]                           f3;
  logic [rv32sde_pkg::RIDX_W-1:0]       rd;
  logic [rv32sde_pkg::XLEN-1:0]         imm_i;
  logic [rv32sde_pkg::XLEN-1:0]         imm_s;
  logic [rv32sde_pkg::XLEN-1:0]         imm_u;
  logic [rv32sde_pkg::XLEN-1:0]         imm_j;
  logic [rv32sde_pkg::XLEN-1:0]         pc_plus4;

  assign opc      = word[6:0];
  assign f3       = word[14:12];
  assign rd       = word[11:7];
  assign imm_i    = {{20{word[31]}}, word[31:20]};
  assign imm_s    = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_u    = {word[31:12], 12'b0};
  assign imm_j    = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    ex                 = '0;
    ex.res.kind        = rv32sde_pkg::KIND_RETIRED;
    ex.res.access_size = rv32sde_pkg::SIZE_NONE;
    ex.res.next_pc     = pc;
    ex.pc_nxt          = pc;
    if (halted) begin
      ex.emit          = 1'b1;
      ex.res.kind      = rv32sde_pkg::KIND_HALT;
      ex.res.halt_code = a0;
    end else if (op == rv32sde_pkg::OP_REPLY) begin
      if (load_pending) begin
        ex.emit     = 1'b1;
        ex.rf_we    = (load_dest != rv32sde_pkg::REG_ZERO);
        ex.rf_waddr = load_dest;
        ex.rf_wdata = {24'b0, load_byte};
        ex.pend_clr = 1'b1;
      end
    end else if (!load_pending) begin
      ex.emit     = 1'b1;
      ex.rf_waddr = rd;
      if (opc == rv32sde_pkg::OPC_OP_IMM && f3 == rv32sde_pkg::F3_ADDI) begin
        ex.rf_we       = (rd != rv32sde_pkg::REG_ZERO);
        ex.rf_wdata    = rs1 + imm_i;
        ex.pc_nxt      = pc_plus4;
        ex.res.next_pc = pc_plus4;
      end else if (opc == rv32sde_pkg::OPC_JAL) begin
        ex.rf_we       = (rd != rv32sde_pkg::REG_ZERO);
        ex.rf_wdata    = pc_plus4;
        ex.pc_nxt      = pc + imm_j;
        ex.res.next_pc = pc + imm_j;
      end else if (opc == rv32sde_pkg::OPC_STORE &&
                   (f3 == rv32sde_pkg::F3_SW || f3 == rv32sde_pkg::F3_SB)) begin
        ex.pc_nxt          = pc_plus4;
        ex.res.next_pc     = pc_plus4;
        ex.res.kind        = rv32sde_pkg::KIND_STORE;
        ex.res.mem_address = rs1 + imm_s;
        if (f3 == rv32sde_pkg::F3_SW) begin
          ex.res.store_data  = rs2;
          ex.res.access_size = rv32sde_pkg::SIZE_WORD;
        end else begin
          ex.res.store_data  = {24'b0, rs2[7:0]};
          ex.res.access_size = rv32sde_pkg::SIZE_BYTE;
        end
      end else if (opc == rv32sde_pkg::OPC_AUIPC) begin
        ex.rf_we       = (rd != rv32sde_pkg::REG_ZERO);
        ex.rf_wdata    = pc + imm_u;
        ex.pc_nxt      = pc_plus4;
        ex.res.next_pc = pc_plus4;
      end else if (opc == rv32sde_pkg::OPC_LOAD && f3 == rv32sde_pkg::F3_LBU) begin
        ex.pend_set        = 1'b1;
        ex.pc_nxt          = pc_plus4;
        ex.res.next_pc     = pc_plus4;
        ex.res.kind        = rv32sde_pkg::KIND_LOAD;
        ex.res.mem_address = rs1 + imm_i;
        ex.res.access_size = rv32sde_pkg::SIZE_BYTE;
      end else if (word == rv32sde_pkg::EBREAK_WORD) begin
        ex.halt_set      = 1'b1;
        ex.res.kind      = rv32sde_pkg::KIND_HALT;
        ex.res.halt_code = a0;
      end else begin
        ex.res.kind = rv32sde_pkg::KIND_INVALID;
      end
    end
  end

endmodule

// ===== hdl/rv32_subset_decode_execute_core.sv =====
// ----------------------------------------------------------------------------
// rv32_subset_decode_execute_core
// Executes addi, jal, auipc, lbu, sb, sw and ebreak, one item per transfer.
// ----------------------------------------------------------------------------
// Takes one instruction word or load reply per cycle while in_ready is high
// and gives at most one result, through the input and result registers.
// The register file sits in a RAM with two registered read ports, read while
// the item enters the input register; a write from the execute stage in that
// same cycle is bypassed. Execute runs between the input register and the
// result register; the sustained rate is one item per clock while the result
// side keeps up. Items that cause no result (a reply with no lbu pending, an
// instruction while one is pending) still pass through execute. A cfg_we write
// loads the pc directly and is meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`include "rv32_subset_decode_execute_core_defines.svh"

module rv32_subset_decode_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_instr_word,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data,
  output logic [2:0]  out_access_size,
  output logic [31:0] out_next_pc,
  output logic [31:0] out_halt_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic                                  in_xfer;
  logic                                  ex_fire;
  logic [rv32sde_pkg::RIDX_W-1:0]        raddr1;
  logic [rv32sde_pkg::RIDX_W-1:0]        raddr2;
  logic [rv32sde_pkg::XLEN-1:0]          rdata1;
  logic [rv32sde_pkg::XLEN-1:0]          rdata2;
  logic [rv32sde_pkg::XLEN-1:0]          rs1;
  logic [rv32sde_pkg::XLEN-1:0]          rs2;
  rv32sde_pkg::exec_t                    ex;

  logic                                  s1_valid_r;
  logic                                  s1_op_r;
  logic [rv32sde_pkg::XLEN-1:0]          s1_word_r;
  logic [7:0]                            s1_byte_r;
  logic                                  s1_byp1_r;
  logic                                  s1_byp2_r;
  logic [rv32sde_pkg::XLEN-1:0]          s1_bypd_r;
  logic                                  s1_v1_r;
  logic                                  s1_v2_r;

  logic [rv32sde_pkg::NREGS-1:0]         rf_vld_r;
  logic [rv32sde_pkg::XLEN-1:0]          a0_r;
  logic [rv32sde_pkg::XLEN-1:0]          pc_r;
  logic                                  halted_r;
  logic                                  pend_r;
  logic [rv32sde_pkg::RIDX_W-1:0]        ld_dest_r;

  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  rv32sde_pkg::result_t                  out_res_r;

  assign ex_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || ex_fire;
  assign in_xfer  = in_valid && in_ready;
  assign raddr1   = in_instr_word[19:15];
  assign raddr2   = in_instr_word[24:20];

  rv32sde_ram #(
    .WIDTH (rv32sde_pkg::XLEN),
    .DEPTH (rv32sde_pkg::NREGS)
  ) u_rf (
    .clk     (clk),
    .we      (ex_fire && ex.rf_we),
    .waddr   (ex.rf_waddr),
    .wdata   (ex.rf_wdata),
    .re      (in_xfer),
    .raddr_a (raddr1),
    .raddr_b (raddr2),
    .rdata_a (rdata1),
    .rdata_b (rdata2)
  );

  assign rs1 = s1_byp1_r ? s1_bypd_r : (s1_v1_r ? rdata1 : '0);
  assign rs2 = s1_byp2_r ? s1_bypd_r : (s1_v2_r ? rdata2 : '0);

  rv32sde_exec u_exec (
    .op           (s1_op_r),
    .word         (s1_word_r),
    .load_byte    (s1_byte_r),
    .rs1          (rs1),
    .rs2          (rs2),
    .a0           (a0_r),
    .pc           (pc_r),
    .halted       (halted_r),
    .load_pending (pend_r),
    .load_dest    (ld_dest_r),
    .ex           (ex)
  );

  // input register, with operand bypass from the execute write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_xfer) begin
      s1_op_r   <= in_opcode;
      s1_word_r <= in_instr_word;
      s1_byte_r <= in_load_byte;
      s1_byp1_r <= ex_fire && ex.rf_we && (ex.rf_waddr == raddr1);
      s1_byp2_r <= ex_fire && ex.rf_we && (ex.rf_waddr == raddr2);
      s1_bypd_r <= ex.rf_wdata;
      s1_v1_r   <= rf_vld_r[raddr1];
      s1_v2_r   <= rf_vld_r[raddr2];
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      a0_r      <= '0;
      pc_r      <= rv32sde_pkg::PC_RESET;
      halted_r  <= 1'b0;
      pend_r    <= 1'b0;
      ld_dest_r <= '0;
    end else begin
      if (ex_fire) begin
        if (ex.rf_we) begin
          rf_vld_r[ex.rf_waddr] <= 1'b1;
          if (ex.rf_waddr == rv32sde_pkg::REG_A0) begin
            a0_r <= ex.rf_wdata;
          end
        end
        pc_r <= ex.pc_nxt;
        if (ex.halt_set) begin
          halted_r <= 1'b1;
        end
        if (ex.pend_set) begin
          pend_r    <= 1'b1;
          ld_dest_r <= ex.rf_waddr;
        end else if (ex.pend_clr) begin
          pend_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ex_fire) begin
      out_valid_nxt = ex.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (ex_fire && ex.emit) begin
      out_res_r <= ex.res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_mem_address = out_res_r.mem_address;
  assign out_store_data  = out_res_r.store_data;
  assign out_access_size = out_res_r.access_size;
  assign out_next_pc     = out_res_r.next_pc;
  assign out_halt_code   = out_res_r.halt_code;

  `RV32SDE_ASSERT_NXT(a_drop_no_result, clk, rst_n, ex_fire && !ex.emit, !out_valid_r)
  `RV32SDE_ASSERT_NXT(a_halt_result, clk, rst_n, ex_fire && halted_r,
                      out_valid_r && out_kind == rv32sde_pkg::KIND_HALT)
  `RV32SDE_ASSERT_NXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `RV32SDE_ASSERT_IMP(a_x0_never_written, clk, rst_n, ex_fire && ex.rf_we,
                      ex.rf_waddr != rv32sde_pkg::REG_ZERO)
  `RV32SDE_ASSERT_NXT(a_stall_holds, clk, rst_n, s1_valid_r && !ex_fire,
                      s1_valid_r && $stable(s1_word_r))

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV32 subset decode/execute core.
// ----------------------------------------------------------------------------
// Runs directed programs for reset pc, immediate extremes, jal offsets, store
// and lbu traffic and invalid encodings, then random instruction streams
// under several boot addresses, and ends with ebreak and the halted state.
// An architectural model tracks registers, pc, the open lbu and the halt
// flag and queues each expected result; the result channel is checked in
// order, field by field. Both channels see random bursts and stalls.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = rv32sde_pkg::OP_INSTR;
  logic [31:0] in_instr_word = '0;
  logic [7:0]  in_load_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_mem_address;
  logic [31:0] out_store_data;
  logic [2:0]  out_access_size;
  logic [31:0] out_next_pc;
  logic [31:0] out_halt_code;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  rv32_subset_decode_execute_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_instr_word   (in_instr_word),
    .in_load_byte    (in_load_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_mem_address (out_mem_address),
    .out_store_data  (out_store_data),
    .out_access_size (out_access_size),
    .out_next_pc     (out_next_pc),
    .out_halt_code   (out_halt_code),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // architectural state of the model
  logic [31:0] arch_regs [rv32sde_pkg::NREGS];
  logic [31:0] arch_pc;
  logic [31:0] boot_pc;
  logic        lbu_waiting;
  logic [4:0]  lbu_rd;
  logic        cpu_halted;

  rv32sde_pkg::result_t trace_q [$];
  int      results_due = 0;
  int      mismatches = 0;
  int      kind_seen [5];
  int      boot_settings = 0;
  int      burst_left = 0;
  int      rx_left = 0;
  bit      rx_on = 1'b0;

  function automatic logic [31:0] i_type(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] s_type(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32sde_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] u_type(logic [4:0] rd, logic [19:0] imm);
    return {imm, rd, rv32sde_pkg::OPC_AUIPC};
  endfunction

  function automatic logic [31:0] j_type(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32sde_pkg::OPC_JAL};
  endfunction

  task automatic set_reg(input logic [4:0] rd, input logic [31:0] v);
    if (rd != rv32sde_pkg::REG_ZERO) arch_regs[rd] = v;
  endtask

  task automatic execute_model(input logic op, input logic [31:0] w, input logic [7:0] b);
    rv32sde_pkg::result_t r;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] s1, s2, immi, imms, immu, immj, pc;
    logic        emit;
    r    = '0;
    pc   = arch_pc;
    emit = 1'b1;
    r.next_pc = pc;
    opc  = w[6:0];
    f3   = w[14:12];
    rd   = w[11:7];
    s1   = arch_regs[w[19:15]];
    s2   = arch_regs[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immu = {w[31:12], 12'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    if (cpu_halted) begin
      r.kind = rv32sde_pkg::KIND_HALT;
      r.halt_code = arch_regs[rv32sde_pkg::REG_A0];
    end else if (op == rv32sde_pkg::OP_REPLY) begin
      if (lbu_waiting) begin
        set_reg(lbu_rd, {24'b0, b});
        lbu_waiting = 1'b0;
        r.kind = rv32sde_pkg::KIND_RETIRED;
      end else begin
        emit = 1'b0;
      end
    end else if (lbu_waiting) begin
      emit = 1'b0;
    end else if (opc == rv32sde_pkg::OPC_OP_IMM && f3 == rv32sde_pkg::F3_ADDI) begin
      set_reg(rd, s1 + immi);
      arch_pc = pc + 32'd4;
      r.kind = rv32sde_pkg::KIND_RETIRED;
    end else if (opc == rv32sde_pkg::OPC_JAL) begin
      set_reg(rd, pc + 32'd4);
      arch_pc = pc + immj;
      r.kind = rv32sde_pkg::KIND_RETIRED;
    end else if (opc == rv32sde_pkg::OPC_STORE &&
                 (f3 == rv32sde_pkg::F3_SW || f3 == rv32sde_pkg::F3_SB)) begin
      arch_pc = pc + 32'd4;
      r.kind = rv32sde_pkg::KIND_STORE;
      r.mem_address = s1 + imms;
      r.store_data = (f3 == rv32sde_pkg::F3_SW) ? s2 : {24'b0, s2[7:0]};
      r.access_size = (f3 == rv32sde_pkg::F3_SW) ? rv32sde_pkg::SIZE_WORD :
                                                   rv32sde_pkg::SIZE_BYTE;
    end else if (opc == rv32sde_pkg::OPC_AUIPC) begin
      set_reg(rd, pc + immu);
      arch_pc = pc + 32'd4;
      r.kind = rv32sde_pkg::KIND_RETIRED;
    end else if (opc == rv32sde_pkg::OPC_LOAD && f3 == rv32sde_pkg::F3_LBU) begin
      lbu_waiting = 1'b1;
      lbu_rd = rd;
      arch_pc = pc + 32'd4;
      r.kind = rv32sde_pkg::KIND_LOAD;
      r.mem_address = s1 + immi;
      r.access_size = rv32sde_pkg::SIZE_BYTE;
    end else if (w == rv32sde_pkg::EBREAK_WORD) begin
      cpu_halted = 1'b1;
      r.kind = rv32sde_pkg::KIND_HALT;
      r.halt_code = arch_regs[rv32sde_pkg::REG_A0];
    end else begin
      r.kind = rv32sde_pkg::KIND_INVALID;
    end
    if (r.kind != rv32sde_pkg::KIND_HALT || cpu_halted)
      r.next_pc = (r.kind == rv32sde_pkg::KIND_RETIRED || r.kind == rv32sde_pkg::KIND_STORE ||
                   r.kind == rv32sde_pkg::KIND_LOAD) ? arch_pc : pc;
    if (emit) begin
      trace_q.push_back(r);
      results_due++;
    end
  endtask

  // one transfer in; bursts keep valid high across items
  task automatic xfer(input logic op, input logic [31:0] w, input logic [7:0] b);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_instr_word <= w;
    in_load_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    execute_model(op, w, b);
    burst_left--;
  endtask

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (trace_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_boot_pc(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    boot_pc = v;
    arch_pc = v;
    boot_settings++;
    @(posedge clk);
  endtask

  // result checker
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rv32sde_pkg::result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (trace_q.size() == 0) begin
        $error("result with none expected: kind %0d next_pc %0h", out_kind, out_next_pc);
        mismatches++;
      end else begin
        e = trace_q.pop_front();
        check_field("kind", {29'b0, e.kind}, {29'b0, out_kind});
        check_field("mem_address", e.mem_address, out_mem_address);
        check_field("store_data", e.store_data, out_store_data);
        check_field("access_size", {29'b0, e.access_size}, {29'b0, out_access_size});
        check_field("next_pc", e.next_pc, out_next_pc);
        check_field("halt_code", e.halt_code, out_halt_code);
        if (e.kind <= rv32sde_pkg::KIND_INVALID) kind_seen[e.kind]++;
      end
    end
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_on = !rx_on;
      if (rx_on)
        rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      else
        rx_left = $urandom_range(1, 5);
      out_ready <= rx_on;
    end
    rx_left--;
  end

  task automatic test_reset_pc();
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, 5'd1,
         rv32sde_pkg::REG_ZERO, 12'h001), 8'h00);
  endtask

  task automatic test_immediates();
    settle();
    load_boot_pc(32'hFFFF_FFFF);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, 5'd1,
         rv32sde_pkg::REG_ZERO, 12'h7FF), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, 5'd2,
         rv32sde_pkg::REG_ZERO, 12'h800), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI,
         rv32sde_pkg::REG_ZERO, 5'd1, 12'h001), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, 5'd8,
         5'd1, 12'h800), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, u_type(5'd3, 20'hFFFFF), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, j_type(5'd4, 21'h0F_FFFE), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, j_type(5'd5, 21'h10_0000), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, j_type(rv32sde_pkg::REG_ZERO, 21'h00_0002), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SW, 5'd2, 5'd1, 12'h7FF), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SB, 5'd1, 5'd3, 12'h800), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SW, rv32sde_pkg::REG_ZERO,
         rv32sde_pkg::REG_ZERO, 12'h000), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SW, 5'd8, 5'd5, 12'h001), 8'h00);
  endtask

  task automatic test_load_reply();
    xfer(rv32sde_pkg::OP_REPLY, 32'h0, 8'h5A);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_LOAD, rv32sde_pkg::F3_LBU, 5'd6,
         rv32sde_pkg::REG_ZERO, 12'hFFF), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, 5'd6,
         rv32sde_pkg::REG_ZERO, 12'h123), 8'h00);
    xfer(rv32sde_pkg::OP_REPLY, 32'hFFFF_FFFF, 8'hFF);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SW, rv32sde_pkg::REG_ZERO, 5'd6,
         12'h010), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_LOAD, rv32sde_pkg::F3_LBU,
         rv32sde_pkg::REG_ZERO, 5'd6, 12'h000), 8'h00);
    xfer(rv32sde_pkg::OP_REPLY, 32'h0, 8'hA5);
    xfer(rv32sde_pkg::OP_INSTR, s_type(rv32sde_pkg::F3_SB, 5'd6, rv32sde_pkg::REG_ZERO,
         12'h000), 8'h00);
  endtask

  task automatic test_invalid();
    xfer(rv32sde_pkg::OP_INSTR, 32'h0000_0000, 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, 32'hFFFF_FFFF, 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, 3'b001, 5'd9, 5'd1, 12'h001),
         8'h00);
    xfer(rv32sde_pkg::OP_INSTR, s_type(3'b001, 5'd1, 5'd2, 12'h004), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_LOAD, 3'b000, 5'd9, 5'd1, 12'h000),
         8'h00);
    xfer(rv32sde_pkg::OP_INSTR, rv32sde_pkg::EBREAK_WORD ^ 32'h0010_0000, 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, rv32sde_pkg::EBREAK_WORD | 32'h8000_0000, 8'h00);
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] w, imm;
    logic [4:0]  rd, rs1, rs2;
    pick = $urandom_range(0, 99);
    w    = $urandom;
    imm  = $urandom;
    rd   = 5'($urandom);
    rs1  = 5'($urandom);
    rs2  = 5'($urandom);
    if (lbu_waiting) begin
      if (pick < 85) xfer(rv32sde_pkg::OP_REPLY, w, 8'($urandom));
      else xfer(rv32sde_pkg::OP_INSTR, w, 8'($urandom));
    end else if (pick >= 96) begin
      xfer(rv32sde_pkg::OP_REPLY, w, 8'($urandom));
    end else begin
      if (pick < 22)
        w = i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI, rd, rs1, imm[11:0]);
      else if (pick < 32) w = j_type(rd, imm[20:0]);
      else if (pick < 42) w = u_type(rd, imm[19:0]);
      else if (pick < 54) w = s_type(rv32sde_pkg::F3_SW, rs1, rs2, imm[11:0]);
      else if (pick < 64) w = s_type(rv32sde_pkg::F3_SB, rs1, rs2, imm[11:0]);
      else if (pick < 80)
        w = i_type(rv32sde_pkg::OPC_LOAD, rv32sde_pkg::F3_LBU, rd, rs1, imm[11:0]);
      else if (pick < 88) w[14:12] = 3'($urandom);
      else if (pick < 92)
        w = {imm[31:15], imm[14:12], rd,
             (pick[0] ? rv32sde_pkg::OPC_STORE : rv32sde_pkg::OPC_LOAD)};
      if (w == rv32sde_pkg::EBREAK_WORD) w = 32'h0;
      xfer(rv32sde_pkg::OP_INSTR, w, 8'($urandom));
    end
  endtask

  task automatic test_random();
    logic [31:0] boots [8];
    int          goal;
    boots = '{32'h0000_0000, 32'hFFFF_FFFF, rv32sde_pkg::PC_RESET, 32'hFFFF_FFFC,
              $urandom, $urandom, $urandom, $urandom};
    foreach (boots[i]) begin
      settle();
      load_boot_pc(boots[i]);
      goal = results_due + 178;
      while (results_due < goal) random_item();
    end
  endtask

  task automatic test_halt();
    settle();
    load_boot_pc(32'h0000_1000);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI,
         rv32sde_pkg::REG_A0, rv32sde_pkg::REG_ZERO, 12'($urandom)), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_LOAD, rv32sde_pkg::F3_LBU, 5'd7,
         rv32sde_pkg::REG_A0, 12'h004), 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, rv32sde_pkg::EBREAK_WORD, 8'h00);
    xfer(rv32sde_pkg::OP_REPLY, 32'h0, 8'h3C);
    xfer(rv32sde_pkg::OP_INSTR, rv32sde_pkg::EBREAK_WORD, 8'h00);
    xfer(rv32sde_pkg::OP_INSTR, i_type(rv32sde_pkg::OPC_OP_IMM, rv32sde_pkg::F3_ADDI,
         rv32sde_pkg::REG_A0, rv32sde_pkg::REG_ZERO, 12'h001), 8'h00);
    xfer(rv32sde_pkg::OP_REPLY, 32'h0, 8'hC3);
    xfer(rv32sde_pkg::OP_INSTR, rv32sde_pkg::EBREAK_WORD, 8'h00);
    settle();
    load_boot_pc(32'h0000_0000);
    xfer(rv32sde_pkg::OP_INSTR, 32'h0000_0000, 8'h00);
  endtask

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    boot_pc     = rv32sde_pkg::PC_RESET;
    arch_pc     = rv32sde_pkg::PC_RESET;
    lbu_waiting = 1'b0;
    lbu_rd      = '0;
    cpu_halted  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_pc();
    test_immediates();
    test_load_reply();
    test_invalid();
    test_random();
    test_halt();
    settle();
    $display("boot addresses used: %0d; results checked: %0d retired, %0d store, %0d lbu,",
             boot_settings + 1, kind_seen[rv32sde_pkg::KIND_RETIRED],
             kind_seen[rv32sde_pkg::KIND_STORE], kind_seen[rv32sde_pkg::KIND_LOAD]);
    $display("  %0d invalid, %0d halted; %0d field mismatches",
             kind_seen[rv32sde_pkg::KIND_INVALID], kind_seen[rv32sde_pkg::KIND_HALT],
             mismatches);
    if (mismatches == 0 && trace_q.size() == 0) begin
      $display("rv32_subset_decode_execute_core: match");
    end else begin
      $display("rv32_subset_decode_execute_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for transfers");
    $display("rv32_subset_decode_execute_core: mismatch");
    $finish;
  end

endmodule
